@@ sv/aabb_pkg.sv @@
// shared types, constants and helpers for the box physics step block
package aabb_pkg;

   localparam int TABLE_SLOTS  = 16;
   localparam int SLOT_W       = $clog2(TABLE_SLOTS);
   localparam int MAX_SUBSTEPS = 10;
   localparam int STEP_W       = $clog2(MAX_SUBSTEPS + 1);
   localparam int VAL_W        = 24;
   localparam int SIZE_W       = 23;
   localparam int CFG_W        = 16;
   localparam int PEN_W        = 27;
   localparam int SUM_W        = 28;
   localparam int DIV_BITS     = VAL_W;
   localparam int DIV_CNT_W    = $clog2(DIV_BITS);

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   localparam logic [1:0] REG_GRAVITY = 2'd0;
   localparam logic [1:0] REG_BODY_W  = 2'd1;
   localparam logic [1:0] REG_BODY_H  = 2'd2;

   localparam logic signed [CFG_W-1:0] GRAVITY_RESET = 16'sd128;
   localparam logic [CFG_W-1:0]        BODY_W_RESET  = 16'd4096;
   localparam logic [CFG_W-1:0]        BODY_H_RESET  = 16'd4096;

   typedef logic signed [VAL_W-1:0] val_type;

   // clamp a wide signed sum to the 24 bit range
   function automatic val_type sat24(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(2 ** (VAL_W - 1) - 1);
      lo = -SUM_W'(2 ** (VAL_W - 1));
      if (v > hi) begin
         return val_type'(hi);
      end else if (v < lo) begin
         return val_type'(lo);
      end
      return v[VAL_W-1:0];
   endfunction

endpackage

@@ sv/aabb_body_physics_step_top.sv @@
// top level of the moving box physics step against a table of static boxes
//
// one moving body box against sixteen static table boxes, all in signed q15.8.
// load and set-body items finish in the cycle of their transfer and give their
// result on the next cycle. a query scans the table one slot a cycle. a tick
// updates x in the cycle of its transfer, finds the substep count by repeated
// add of the body height, then for each of its 1..10 substeps runs two
// divisions on the shared bit serial divider, two saturating adds and a table
// scan in which ST_BOXA skips a disabled slot and takes an enabled one on to
// ST_BOXB (penetrations, then push). the block takes no new item while busy or
// while a result waits on rsp_stall. csr writes are always ready and must come
// only while idle.
module aabb_body_physics_step_top
   import aabb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_kind,
   input  logic [3:0]               req_slot,
   input  logic signed [VAL_W-1:0]  req_pos_x,
   input  logic signed [VAL_W-1:0]  req_pos_y,
   input  logic [SIZE_W-1:0]        req_size_w,
   input  logic [SIZE_W-1:0]        req_size_h,
   input  logic                     req_is_trigger,
   input  logic                     req_is_valid,
   input  logic signed [VAL_W-1:0]  req_speed_x,
   input  logic signed [VAL_W-1:0]  req_speed_y,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [VAL_W-1:0]  rsp_body_x,
   output logic signed [VAL_W-1:0]  rsp_body_y,
   output logic signed [VAL_W-1:0]  rsp_vel_x,
   output logic signed [VAL_W-1:0]  rsp_vel_y,
   output logic                     rsp_landed,
   output logic                     rsp_bumped_head,
   output logic                     rsp_hit_side,
   output logic                     rsp_touched_trigger,
   output logic                     rsp_hit_found,
   output logic [3:0]               rsp_hit_slot,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [CFG_W-1:0]         csr_data
);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_STEPS = 4'd1;
   localparam logic [3:0] ST_DIVG  = 4'd2;
   localparam logic [3:0] ST_ADDV  = 4'd3;
   localparam logic [3:0] ST_DIVV  = 4'd4;
   localparam logic [3:0] ST_ADDP  = 4'd5;
   localparam logic [3:0] ST_BOXA  = 4'd6;
   localparam logic [3:0] ST_BOXB  = 4'd7;
   localparam logic [3:0] ST_QUERY = 4'd8;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

   // static box table, registers read at the sequencer's slot
   logic signed [VAL_W-1:0] box_left_ff   [TABLE_SLOTS];
   logic signed [VAL_W-1:0] box_top_ff    [TABLE_SLOTS];
   logic [SIZE_W-1:0]       box_width_ff  [TABLE_SLOTS];
   logic [SIZE_W-1:0]       box_height_ff [TABLE_SLOTS];
   logic                    box_trigger_ff[TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0]  box_enabled_ff;

   logic [3:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [CFG_W-1:0] gravity_ff;
   logic [CFG_W-1:0]        body_w_ff, body_h_ff;
   val_type                 pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   val_type                 spd_x_ff, spd_x_in, spd_y_ff, spd_y_in;
   logic                    landed_ff, landed_in, head_ff, head_in;
   logic                    side_ff, side_in, trig_ff, trig_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic [STEP_W-1:0]       steps_ff, steps_in, sub_ff, sub_in;
   logic [VAL_W:0]          two_avy_ff, two_avy_in;
   logic [VAL_W+1:0]        acc_ff, acc_in;
   logic signed [VAL_W-1:0] qry_x_ff, qry_y_ff;

   // shared bit serial divider (magnitude by steps)
   logic [VAL_W-1:0]        div_mag_ff, div_mag_in;
   logic [STEP_W-1:0]       div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic                    div_neg_ff, div_neg_in;

   // penetrations of the current box
   logic signed [PEN_W-1:0] ol_ff, or_ff, ot_ff, ob_ff;
   logic signed [PEN_W-1:0] ol_in, or_in, ot_in, ob_in;

   logic                    req_xfer, rsp_xfer;
   logic [STEP_W:0]         div_try;
   logic                    div_last;
   logic signed [VAL_W:0]   quot;
   logic [VAL_W+1:0]        acc_next;
   logic signed [PEN_W-1:0] mx, my;
   logic signed [PEN_W-1:0] cur_l, cur_t, cur_r, cur_b, bx, by;
   logic signed [PEN_W-1:0] qx, qy;
   logic                    contains;
   val_type                 grav_ext, vy_new, abs_src;
   logic                    substep_last;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   // one restoring step of the divider
   assign div_try  = {div_rem_ff, div_mag_ff[VAL_W-1]};
   assign div_last = (div_cnt_ff == DIV_CNT_W'(DIV_BITS - 1));
   assign quot     = div_neg_ff ? -$signed({1'b0, div_mag_ff}) : $signed({1'b0, div_mag_ff});

   assign acc_next = acc_ff + (VAL_W + 2)'(body_h_ff);
   assign grav_ext = VAL_W'(gravity_ff);

   // current table entry at full precision
   assign cur_l = PEN_W'(box_left_ff[idx_ff]);
   assign cur_t = PEN_W'(box_top_ff[idx_ff]);
   assign cur_r = cur_l + $signed({4'd0, box_width_ff[idx_ff]});
   assign cur_b = cur_t + $signed({4'd0, box_height_ff[idx_ff]});
   assign bx    = PEN_W'(pos_x_ff);
   assign by    = PEN_W'(pos_y_ff);
   assign qx    = PEN_W'(qry_x_ff);
   assign qy    = PEN_W'(qry_y_ff);
   assign contains = (qx >= cur_l) && (qx <= cur_r) && (qy >= cur_t) && (qy <= cur_b);

   assign mx = (ol_ff < or_ff) ? ol_ff : or_ff;
   assign my = (ot_ff < ob_ff) ? ot_ff : ob_ff;
   assign substep_last = (sub_ff == steps_ff - STEP_W'(1));

   // query point held for the table scan
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         qry_x_ff <= req_pos_x;
         qry_y_ff <= req_pos_y;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      spd_x_in     = spd_x_ff;
      spd_y_in     = spd_y_ff;
      landed_in    = landed_ff;
      head_in      = head_ff;
      side_in      = side_ff;
      trig_in      = trig_ff;
      found_in     = found_ff;
      hit_slot_in  = hit_slot_ff;
      idx_in       = idx_ff;
      steps_in     = steps_ff;
      sub_in       = sub_ff;
      two_avy_in   = two_avy_ff;
      acc_in       = acc_ff;
      div_mag_in   = div_mag_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      ol_in        = ol_ff;
      or_in        = or_ff;
      ot_in        = ot_ff;
      ob_in        = ob_ff;
      vy_new       = '0;
      abs_src      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               landed_in   = 1'b0;
               head_in     = 1'b0;
               side_in     = 1'b0;
               trig_in     = 1'b0;
               found_in    = 1'b0;
               hit_slot_in = '0;
               idx_in      = '0;
               sub_in      = '0;
               acc_in      = '0;
               steps_in    = '0;
               case (req_kind)
                  KIND_SET: begin
                     pos_x_in     = req_pos_x;
                     pos_y_in     = req_pos_y;
                     spd_x_in     = req_speed_x;
                     spd_y_in     = req_speed_y;
                     rsp_valid_in = 1'b1;
                  end
                  KIND_TICK: begin
                     pos_x_in   = sat24(SUM_W'(pos_x_ff) + SUM_W'(spd_x_ff));
                     two_avy_in = spd_y_ff[VAL_W-1] ?
                                  (VAL_W + 1)'(-SUM_W'(spd_y_ff)) << 1 :
                                  (VAL_W + 1)'(spd_y_ff) << 1;
                     if (body_h_ff == '0) begin
                        steps_in = STEP_W'(MAX_SUBSTEPS);
                        state_in = ST_DIVG;
                     end else begin
                        state_in = ST_STEPS;
                     end
                     div_mag_in = grav_ext[VAL_W-1] ? VAL_W'(-grav_ext) : VAL_W'(grav_ext);
                     div_neg_in = grav_ext[VAL_W-1];
                     div_rem_in = '0;
                     div_cnt_in = '0;
                  end
                  KIND_QUERY: begin
                     state_in = ST_QUERY;
                  end
                  default: begin
                     // table load is written in the table block
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_STEPS: begin
            // count multiples of the height that fit in twice the speed
            if ((acc_next > (VAL_W + 2)'(two_avy_ff)) ||
                (steps_ff == STEP_W'(MAX_SUBSTEPS - 1))) begin
               steps_in = steps_ff + STEP_W'(1);
               state_in = ST_DIVG;
            end else begin
               acc_in   = acc_next;
               steps_in = steps_ff + STEP_W'(1);
            end
         end
         ST_DIVG, ST_DIVV: begin
            if (div_try >= (STEP_W + 1)'(steps_ff)) begin
               div_rem_in = STEP_W'(div_try - (STEP_W + 1)'(steps_ff));
               div_mag_in = {div_mag_ff[VAL_W-2:0], 1'b1};
            end else begin
               div_rem_in = STEP_W'(div_try);
               div_mag_in = {div_mag_ff[VAL_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_last) begin
               state_in = (state_ff == ST_DIVG) ? ST_ADDV : ST_ADDP;
            end
         end
         ST_ADDV: begin
            vy_new     = sat24(SUM_W'(spd_y_ff) + SUM_W'(quot));
            spd_y_in   = vy_new;
            abs_src    = vy_new;
            div_mag_in = abs_src[VAL_W-1] ? VAL_W'(-abs_src) : VAL_W'(abs_src);
            div_neg_in = abs_src[VAL_W-1];
            div_rem_in = '0;
            div_cnt_in = '0;
            state_in   = ST_DIVV;
         end
         ST_ADDP: begin
            pos_y_in = sat24(SUM_W'(pos_y_ff) + SUM_W'(quot));
            idx_in   = '0;
            state_in = ST_BOXA;
         end
         ST_BOXA: begin
            if (box_enabled_ff[idx_ff]) begin
               ol_in    = bx + PEN_W'(body_w_ff) - cur_l;
               or_in    = cur_r - bx;
               ot_in    = by + PEN_W'(body_h_ff) - cur_t;
               ob_in    = cur_b - by;
               state_in = ST_BOXB;
            end else if (idx_ff != LAST_SLOT) begin
               idx_in = idx_ff + SLOT_W'(1);
            end else if (substep_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               sub_in     = sub_ff + STEP_W'(1);
               div_mag_in = grav_ext[VAL_W-1] ? VAL_W'(-grav_ext) : VAL_W'(grav_ext);
               div_neg_in = grav_ext[VAL_W-1];
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = ST_DIVG;
            end
         end
         ST_BOXB: begin
            // open overlap: every penetration strictly positive
            if ((ol_ff > 0) && (or_ff > 0) && (ot_ff > 0) && (ob_ff > 0)) begin
               hit_slot_in = idx_ff;
               if (box_trigger_ff[idx_ff]) begin
                  trig_in = 1'b1;
               end else if (my < mx) begin
                  spd_y_in = '0;
                  if (ot_ff < ob_ff) begin
                     pos_y_in  = sat24(SUM_W'(pos_y_ff) - SUM_W'(ot_ff));
                     landed_in = 1'b1;
                  end else begin
                     pos_y_in = sat24(SUM_W'(pos_y_ff) + SUM_W'(ob_ff));
                     head_in  = 1'b1;
                  end
               end else begin
                  if (ol_ff < or_ff) begin
                     pos_x_in = sat24(SUM_W'(pos_x_ff) - SUM_W'(ol_ff));
                  end else begin
                     pos_x_in = sat24(SUM_W'(pos_x_ff) + SUM_W'(or_ff));
                  end
                  spd_x_in = '0;
                  side_in  = 1'b1;
               end
            end
            if (idx_ff != LAST_SLOT) begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_BOXA;
            end else if (substep_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               sub_in     = sub_ff + STEP_W'(1);
               div_mag_in = grav_ext[VAL_W-1] ? VAL_W'(-grav_ext) : VAL_W'(grav_ext);
               div_neg_in = grav_ext[VAL_W-1];
               div_rem_in = '0;
               div_cnt_in = '0;
               state_in   = ST_DIVG;
            end
         end
         ST_QUERY: begin
            // closed containment, lowest slot wins
            if (box_enabled_ff[idx_ff] && contains) begin
               found_in     = 1'b1;
               hit_slot_in  = idx_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (idx_ff == LAST_SLOT) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         box_enabled_ff <= '0;
         gravity_ff     <= GRAVITY_RESET;
         body_w_ff      <= BODY_W_RESET;
         body_h_ff      <= BODY_H_RESET;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         spd_x_ff       <= '0;
         spd_y_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         spd_x_ff     <= spd_x_in;
         spd_y_ff     <= spd_y_in;
         if (req_xfer && (req_kind == KIND_LOAD)) begin
            box_enabled_ff[req_slot] <= req_is_valid;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRAVITY: gravity_ff <= csr_data;
               REG_BODY_W:  body_w_ff  <= csr_data;
               REG_BODY_H:  body_h_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // table payload and working registers
   always_ff @(posedge clock) begin
      if (req_xfer && (req_kind == KIND_LOAD)) begin
         box_left_ff[req_slot]    <= req_pos_x;
         box_top_ff[req_slot]     <= req_pos_y;
         box_width_ff[req_slot]   <= req_size_w;
         box_height_ff[req_slot]  <= req_size_h;
         box_trigger_ff[req_slot] <= req_is_trigger;
      end
      landed_ff   <= landed_in;
      head_ff     <= head_in;
      side_ff     <= side_in;
      trig_ff     <= trig_in;
      found_ff    <= found_in;
      hit_slot_ff <= hit_slot_in;
      idx_ff      <= idx_in;
      steps_ff    <= steps_in;
      sub_ff      <= sub_in;
      two_avy_ff  <= two_avy_in;
      acc_ff      <= acc_in;
      div_mag_ff  <= div_mag_in;
      div_rem_ff  <= div_rem_in;
      div_cnt_ff  <= div_cnt_in;
      div_neg_ff  <= div_neg_in;
      ol_ff       <= ol_in;
      or_ff       <= or_in;
      ot_ff       <= ot_in;
      ob_ff       <= ob_in;
   end

   // result fields hold while the transfer waits, input is stalled meanwhile
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_body_x          = pos_x_ff;
   assign rsp_body_y          = pos_y_ff;
   assign rsp_vel_x           = spd_x_ff;
   assign rsp_vel_y           = spd_y_ff;
   assign rsp_landed          = landed_ff;
   assign rsp_bumped_head     = head_ff;
   assign rsp_hit_side        = side_ff;
   assign rsp_touched_trigger = trig_ff;
   assign rsp_hit_found       = found_ff;
   assign rsp_hit_slot        = 4'(hit_slot_ff);

endmodule

@@ tb/tb_aabb_body_physics_step_top.sv @@
// self-checking testbench for the moving box physics step block
module tb_aabb_body_physics_step_top
   import aabb_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // one input transfer and one result transfer, at the block's widths
   typedef struct {
      logic [1:0]        kind;
      logic [3:0]        slot;
      val_type           px;
      val_type           py;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      logic              trig;
      logic              vld;
      val_type           sx;
      val_type           sy;
   } phys_item_type;

   typedef struct {
      val_type    x;
      val_type    y;
      val_type    vx;
      val_type    vy;
      logic       landed;
      logic       head;
      logic       side;
      logic       trig;
      logic       found;
      logic [3:0] slot;
   } body_result_type;

   // directed rows: a result is typed in only where it is obvious
   typedef struct {
      phys_item_type   item;
      bit              known;
      body_result_type res;
   } script_row_type;

   typedef enum int {CONTACT_NONE, CONTACT_TRIGGER, CONTACT_LANDED, CONTACT_HEAD,
                     CONTACT_SIDE} contact_type;

   localparam longint MAX24 = 64'sd8388607;
   localparam longint MIN24 = -64'sd8388608;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_kind;
   logic [3:0] req_slot;
   logic signed [VAL_W-1:0] req_pos_x, req_pos_y, req_speed_x, req_speed_y;
   logic [SIZE_W-1:0] req_size_w, req_size_h;
   logic req_is_trigger, req_is_valid;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [VAL_W-1:0] rsp_body_x, rsp_body_y, rsp_vel_x, rsp_vel_y;
   logic rsp_landed, rsp_bumped_head, rsp_hit_side, rsp_touched_trigger, rsp_hit_found;
   logic [3:0] rsp_hit_slot;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   aabb_body_physics_step_top dut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the body, the box table and the registers
   longint gravity_q, body_w_q, body_h_q;
   longint pos_x_q, pos_y_q, spd_x_q, spd_y_q;
   longint box_l[TABLE_SLOTS], box_t[TABLE_SLOTS], box_w[TABLE_SLOTS], box_h[TABLE_SLOTS];
   bit box_trig[TABLE_SLOTS], box_on[TABLE_SLOTS];

   body_result_type expected_results[$];
   int fails = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int n_items = 0, n_ticks = 0, n_contacts = 0, n_query_hits = 0;

   function automatic longint clamp24(input longint v);
      if (v > MAX24) return MAX24;
      if (v < MIN24) return MIN24;
      return v;
   endfunction

   // push the body out of one box along the axis of least penetration
   function automatic contact_type push_out(input int i);
      longint r, b, ol, orr, ot, ob, mx, my;
      r = box_l[i] + box_w[i];
      b = box_t[i] + box_h[i];
      // open intervals: touching edges never collide
      if (!(pos_x_q < r && box_l[i] < pos_x_q + body_w_q &&
            pos_y_q < b && box_t[i] < pos_y_q + body_h_q)) return CONTACT_NONE;
      if (box_trig[i]) return CONTACT_TRIGGER;
      ol  = pos_x_q + body_w_q - box_l[i];
      orr = r - pos_x_q;
      ot  = pos_y_q + body_h_q - box_t[i];
      ob  = b - pos_y_q;
      mx  = (ol < orr) ? ol : orr;
      my  = (ot < ob) ? ot : ob;
      // ties go to the horizontal push
      if (my < mx) begin
         spd_y_q = 0;
         if (ot < ob) begin
            pos_y_q = clamp24(pos_y_q - ot);
            return CONTACT_LANDED;
         end
         pos_y_q = clamp24(pos_y_q + ob);
         return CONTACT_HEAD;
      end
      if (ol < orr) pos_x_q = clamp24(pos_x_q - ol);
      else pos_x_q = clamp24(pos_x_q + orr);
      spd_x_q = 0;
      return CONTACT_SIDE;
   endfunction

   task automatic predict_step(input phys_item_type it, output body_result_type r);
      longint steps, avy, qx, qy;
      contact_type c;
      r = '{default: '0};
      qx = longint'(it.px);
      qy = longint'(it.py);
      case (it.kind)
         KIND_LOAD: begin
            box_l[it.slot]    = qx;
            box_t[it.slot]    = qy;
            box_w[it.slot]    = longint'(it.w);
            box_h[it.slot]    = longint'(it.h);
            box_trig[it.slot] = it.trig;
            box_on[it.slot]   = it.vld;
         end
         KIND_SET: begin
            pos_x_q = qx;
            pos_y_q = qy;
            spd_x_q = longint'(it.sx);
            spd_y_q = longint'(it.sy);
         end
         KIND_TICK: begin
            pos_x_q = clamp24(pos_x_q + spd_x_q);
            avy = (spd_y_q < 0) ? -spd_y_q : spd_y_q;
            if (body_h_q == 0) steps = MAX_SUBSTEPS;
            else steps = (avy * 2) / body_h_q + 1;
            if (steps > MAX_SUBSTEPS) steps = MAX_SUBSTEPS;
            for (int k = 0; k < steps; k++) begin
               spd_y_q = clamp24(spd_y_q + gravity_q / steps);
               pos_y_q = clamp24(pos_y_q + spd_y_q / steps);
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (box_on[i]) begin
                     c = push_out(i);
                     if (c != CONTACT_NONE) begin
                        r.slot = 4'(i);
                        case (c)
                           CONTACT_TRIGGER: r.trig   = 1'b1;
                           CONTACT_LANDED:  r.landed = 1'b1;
                           CONTACT_HEAD:    r.head   = 1'b1;
                           default:         r.side   = 1'b1;
                        endcase
                     end
                  end
               end
            end
         end
         default: begin
            // closed intervals: a point on an edge hits
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (box_on[i] && !r.found && qx >= box_l[i] && qx <= box_l[i] + box_w[i] &&
                   qy >= box_t[i] && qy <= box_t[i] + box_h[i]) begin
                  r.found = 1'b1;
                  r.slot  = 4'(i);
               end
            end
         end
      endcase
      r.x  = val_type'(pos_x_q);
      r.y  = val_type'(pos_y_q);
      r.vx = val_type'(spd_x_q);
      r.vy = val_type'(spd_y_q);
   endtask

   function automatic phys_item_type mk_load(input int slot, input longint px, py, w, h,
                                             input bit trig, vld);
      phys_item_type it;
      it = '{default: '0};
      it.kind = KIND_LOAD;
      it.slot = 4'(slot);
      it.px = val_type'(px);
      it.py = val_type'(py);
      it.w = SIZE_W'(w);
      it.h = SIZE_W'(h);
      it.trig = trig;
      it.vld = vld;
      return it;
   endfunction

   function automatic phys_item_type mk_set(input longint px, py, sx, sy);
      phys_item_type it;
      it = '{default: '0};
      it.kind = KIND_SET;
      it.px = val_type'(px);
      it.py = val_type'(py);
      it.sx = val_type'(sx);
      it.sy = val_type'(sy);
      return it;
   endfunction

   function automatic phys_item_type mk_other(input logic [1:0] kind, input longint px, py);
      phys_item_type it;
      it = '{default: '0};
      it.kind = kind;
      it.px = val_type'(px);
      it.py = val_type'(py);
      return it;
   endfunction

   function automatic longint near(input int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   // mostly well-formed scenes near the origin, some items with every bit random
   function automatic phys_item_type random_item();
      phys_item_type it;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         it.kind = 2'($urandom);
         it.slot = 4'($urandom);
         it.px = val_type'($urandom);
         it.py = val_type'($urandom);
         it.w = SIZE_W'($urandom);
         it.h = SIZE_W'($urandom);
         it.trig = 1'($urandom);
         it.vld = 1'($urandom);
         it.sx = val_type'($urandom);
         it.sy = val_type'($urandom);
      end else if (pick < 28) begin
         it = mk_load($urandom_range(15), near('h6000), near('h6000),
                      $urandom_range('h3000), $urandom_range('h3000),
                      $urandom_range(3) == 0, $urandom_range(4) != 0);
      end else if (pick < 42) begin
         it = mk_set(near('h4000), near('h4000), near('h600), near('h900));
      end else if (pick < 82) begin
         it = mk_other(KIND_TICK, 0, 0);
      end else begin
         it = mk_other(KIND_QUERY, near('h6000), near('h6000));
      end
      return it;
   endfunction

   // one input transfer, with a random gap ahead of it
   task automatic send_item(input phys_item_type it, input bit known,
                            input body_result_type known_res);
      body_result_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_kind       <= it.kind;
      req_slot       <= it.slot;
      req_pos_x      <= it.px;
      req_pos_y      <= it.py;
      req_size_w     <= it.w;
      req_size_h     <= it.h;
      req_is_trigger <= it.trig;
      req_is_valid   <= it.vld;
      req_speed_x    <= it.sx;
      req_speed_y    <= it.sy;
      do @(posedge clock); while (req_stall);
      predict_step(it, r);
      if (known) expected_results.push_back(known_res);
      else expected_results.push_back(r);
      n_items++;
      if (it.kind == KIND_TICK) n_ticks++;
      if (r.landed || r.head || r.side || r.trig) n_contacts++;
      if (r.found) n_query_hits++;
   endtask

   // register writes only once the block has drained
   task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_GRAVITY: gravity_q = longint'(signed'(data));
         REG_BODY_W:  body_w_q  = longint'(data);
         REG_BODY_H:  body_h_q  = longint'(data);
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, want, got);
         fails++;
      end
   endtask

   // result side: random stall, compare each transfer with the oldest expectation
   always @(posedge clock) begin
      body_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result transfer, body_x %0d", $realtime, rsp_body_x);
               fails++;
            end else begin
               e = expected_results.pop_front();
               check_field("body_x", e.x, rsp_body_x);
               check_field("body_y", e.y, rsp_body_y);
               check_field("vel_x", e.vx, rsp_vel_x);
               check_field("vel_y", e.vy, rsp_vel_y);
               check_field("landed", e.landed, rsp_landed);
               check_field("bumped_head", e.head, rsp_bumped_head);
               check_field("hit_side", e.side, rsp_hit_side);
               check_field("touched_trigger", e.trig, rsp_touched_trigger);
               check_field("hit_found", e.found, rsp_hit_found);
               check_field("hit_slot", e.slot, rsp_hit_slot);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // hard limit on the whole run
   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      script_row_type rows[$];
      body_result_type zero_res, ext_res;
      int idle_sets[4][2];
      int cfg_sets[6][3];

      idle_sets = '{'{0, 0}, '{58, 0}, '{0, 58}, '{32, 32}};
      cfg_sets = '{'{128, 4096, 4096}, '{-32768, 1, 1}, '{32767, 65535, 65535},
                   '{0, 'h800, 'h2000}, '{-200, 'h3000, 'h800}, '{64, 4096, 4096}};

      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_LOAD;
      req_slot = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_size_w = '0;
      req_size_h = '0;
      req_is_trigger = 1'b0;
      req_is_valid = 1'b0;
      req_speed_x = '0;
      req_speed_y = '0;
      csr_valid = 1'b0;
      csr_index = REG_GRAVITY;
      csr_data = '0;

      // predictor state after reset
      gravity_q = GRAVITY_RESET;
      body_w_q = BODY_W_RESET;
      body_h_q = BODY_H_RESET;
      pos_x_q = 0;
      pos_y_q = 0;
      spd_x_q = 0;
      spd_y_q = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         box_l[i] = 0;
         box_t[i] = 0;
         box_w[i] = 0;
         box_h[i] = 0;
         box_trig[i] = 0;
         box_on[i] = 0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      zero_res = '{default: '0};
      ext_res = zero_res;
      ext_res.x = val_type'(MAX24);
      ext_res.y = val_type'(MIN24);
      ext_res.vx = val_type'(MAX24);
      ext_res.vy = val_type'(MIN24);

      // query on an empty table, then load a floor: nothing moves yet
      rows.push_back('{mk_other(KIND_QUERY, 0, 0), 1, zero_res});
      rows.push_back('{mk_load(0, -'h10000, 'h2000, 'h20000, 'h1000, 0, 1), 1, zero_res});
      // body sunk into the floor top lands
      rows.push_back('{mk_set(0, 'h1800, 0, 0), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // ceiling hit while moving up
      rows.push_back('{mk_load(1, -'h10000, -'h3000, 'h20000, 'h1000, 0, 1), 0, zero_res});
      rows.push_back('{mk_set(0, -'h2800, 0, -'h100), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // wall on the right
      rows.push_back('{mk_load(2, 'h2000, -'h10000, 'h1000, 'h20000, 0, 1), 0, zero_res});
      rows.push_back('{mk_set('h1800, 0, 'h100, 0), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // trigger box over the body only reports
      rows.push_back('{mk_load(3, -'h800, -'h800, 'h2000, 'h2000, 1, 1), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // clear three of the boxes, then a tick with no box in reach
      rows.push_back('{mk_load(0, 0, 0, 0, 0, 0, 0), 0, zero_res});
      rows.push_back('{mk_load(1, 0, 0, 0, 0, 0, 0), 0, zero_res});
      rows.push_back('{mk_load(3, 0, 0, 0, 0, 0, 0), 0, zero_res});
      rows.push_back('{mk_set(-'h1000, -'h80, 0, -'h80), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // query on a box corner edge hits, just outside misses; an empty box inside the body still collides
      rows.push_back('{mk_load(4, 'h4000, 'h4000, 0, 0, 0, 1), 0, zero_res});
      rows.push_back('{mk_other(KIND_QUERY, 'h4000, 'h4000), 0, zero_res});
      rows.push_back('{mk_other(KIND_QUERY, 'h4001, 'h4000), 0, zero_res});
      rows.push_back('{mk_set('h3800, 'h3800, 0, 0), 0, zero_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // extreme body values, saturating tick with the most substeps
      rows.push_back('{mk_set(MAX24, MIN24, MAX24, MIN24), 1, ext_res});
      rows.push_back('{mk_other(KIND_TICK, 0, 0), 0, zero_res});
      // widest possible table box in the top slot
      rows.push_back('{mk_load(15, MIN24, MIN24, 'h7FFFFF, 'h7FFFFF, 1, 1), 0, zero_res});
      rows.push_back('{mk_other(KIND_QUERY, MAX24, MAX24), 0, zero_res});

      foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);

      // random phases over register settings and idle patterns
      for (int p = 0; p < 6; p++) begin
         write_reg(REG_GRAVITY, CFG_W'(cfg_sets[p][0]));
         write_reg(REG_BODY_W, CFG_W'(cfg_sets[p][1]));
         write_reg(REG_BODY_H, CFG_W'(cfg_sets[p][2]));
         send_idle_pct = idle_sets[p % 4][0];
         recv_stall_pct = idle_sets[p % 4][1];
         for (int n = 0; n < 300; n++) send_item(random_item(), 0, zero_res);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("tb: %0d transfers, %0d ticks, %0d with contact, %0d query hits",
               n_items, n_ticks, n_contacts, n_query_hits);
      $display("tb: six register settings, four idle patterns");
      if (fails == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
